// ----- rtl/csvs_pkg.sv -----
// Package for the clock-sweep victim selector: item types, opcodes and the microcode table.
package csvs_pkg;

  // Default pool size.
  localparam int NUM_FRAMES_DEF = 256;

  // Request opcodes.
  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // Status codes.
  localparam logic ST_OK      = 1'b0;
  localparam logic ST_NO_FREE = 1'b1;

  // Input item.
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] frame_index;
    logic       pinned;
    logic [2:0] usage_val;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [7:0]  victim_index;
    logic        status;
    logic [7:0]  sweep_start;
    logic [31:0] passes_done;
    logic [31:0] allocs_seen;
  } out_item_t;

  // Per-frame state as held in the frame memory.
  typedef struct packed {
    logic       in_list;
    logic       pinned;
    logic [2:0] usage;
  } frame_state_t;

  // Step counter width.
  localparam int PC_W = 4;

  // Datapath actions.
  localparam logic [3:0] A_NONE     = 4'd0;
  localparam logic [3:0] A_INIT     = 4'd1;
  localparam logic [3:0] A_LATCH    = 4'd2;
  localparam logic [3:0] A_ALLOC    = 4'd3;
  localparam logic [3:0] A_RD_HEAD  = 4'd4;
  localparam logic [3:0] A_POP      = 4'd5;
  localparam logic [3:0] A_SW_SETUP = 4'd6;
  localparam logic [3:0] A_RD_HAND  = 4'd7;
  localparam logic [3:0] A_SW_EVAL  = 4'd8;
  localparam logic [3:0] A_RD_IDX   = 4'd9;
  localparam logic [3:0] A_FREE_WR  = 4'd10;
  localparam logic [3:0] A_STATE_WR = 4'd11;
  localparam logic [3:0] A_DONE     = 4'd12;

  // Branch conditions.
  localparam logic [2:0] C_NEVER     = 3'd0;
  localparam logic [2:0] C_ALWAYS    = 3'd1;
  localparam logic [2:0] C_DISP      = 3'd2;
  localparam logic [2:0] C_INIT_LAST = 3'd3;
  localparam logic [2:0] C_HEAD_END  = 3'd4;
  localparam logic [2:0] C_POP_HIT   = 3'd5;
  localparam logic [2:0] C_SW_END    = 3'd6;
  localparam logic [2:0] C_IDX_BAD   = 3'd7;

  // Where to go when the condition is false.
  localparam logic [1:0] F_INC  = 2'd0;
  localparam logic [1:0] F_DEC  = 2'd1;
  localparam logic [1:0] F_STAY = 2'd2;

  // Step addresses.
  localparam logic [PC_W-1:0] P_INIT    = 4'd0;
  localparam logic [PC_W-1:0] P_IDLE    = 4'd1;
  localparam logic [PC_W-1:0] P_ALLOC   = 4'd2;
  localparam logic [PC_W-1:0] P_POPCHK  = 4'd3;
  localparam logic [PC_W-1:0] P_POP     = 4'd4;
  localparam logic [PC_W-1:0] P_SWSET   = 4'd5;
  localparam logic [PC_W-1:0] P_SWRD    = 4'd6;
  localparam logic [PC_W-1:0] P_SWEV    = 4'd7;
  localparam logic [PC_W-1:0] P_FREE    = 4'd8;
  localparam logic [PC_W-1:0] P_FREEWR  = 4'd9;
  localparam logic [PC_W-1:0] P_WRST    = 4'd10;
  localparam logic [PC_W-1:0] P_WRSTWR  = 4'd11;
  localparam logic [PC_W-1:0] P_DONE    = 4'd12;

  // One control word.
  typedef struct packed {
    logic [3:0]      act;
    logic [2:0]      cond;
    logic [1:0]      fnext;
    logic [PC_W-1:0] tgt;
  } ctl_word_t;

  // Microcode table.
  function automatic ctl_word_t ucode_rom(input logic [PC_W-1:0] pc);
    ctl_word_t w;
    case (pc)
      P_INIT:   w = '{act: A_INIT,     cond: C_INIT_LAST, fnext: F_STAY, tgt: P_IDLE};
      P_IDLE:   w = '{act: A_LATCH,    cond: C_DISP,      fnext: F_STAY, tgt: P_IDLE};
      P_ALLOC:  w = '{act: A_ALLOC,    cond: C_NEVER,     fnext: F_INC,  tgt: P_IDLE};
      P_POPCHK: w = '{act: A_RD_HEAD,  cond: C_HEAD_END,  fnext: F_INC,  tgt: P_SWSET};
      P_POP:    w = '{act: A_POP,      cond: C_POP_HIT,   fnext: F_DEC,  tgt: P_DONE};
      P_SWSET:  w = '{act: A_SW_SETUP, cond: C_NEVER,     fnext: F_INC,  tgt: P_IDLE};
      P_SWRD:   w = '{act: A_RD_HAND,  cond: C_NEVER,     fnext: F_INC,  tgt: P_IDLE};
      P_SWEV:   w = '{act: A_SW_EVAL,  cond: C_SW_END,    fnext: F_DEC,  tgt: P_DONE};
      P_FREE:   w = '{act: A_RD_IDX,   cond: C_IDX_BAD,   fnext: F_INC,  tgt: P_DONE};
      P_FREEWR: w = '{act: A_FREE_WR,  cond: C_ALWAYS,    fnext: F_INC,  tgt: P_DONE};
      P_WRST:   w = '{act: A_RD_IDX,   cond: C_IDX_BAD,   fnext: F_INC,  tgt: P_DONE};
      P_WRSTWR: w = '{act: A_STATE_WR, cond: C_ALWAYS,    fnext: F_INC,  tgt: P_DONE};
      P_DONE:   w = '{act: A_DONE,     cond: C_ALWAYS,    fnext: F_INC,  tgt: P_IDLE};
      default:  w = '{act: A_NONE,     cond: C_ALWAYS,    fnext: F_INC,  tgt: P_IDLE};
    endcase
    return w;
  endfunction

  // Entry step of each opcode.
  function automatic logic [PC_W-1:0] op_entry(input logic [1:0] op);
    logic [PC_W-1:0] e;
    case (op)
      OP_ALLOC: e = P_ALLOC;
      OP_FREE:  e = P_FREE;
      OP_WRITE: e = P_WRST;
      default:  e = P_DONE;
    endcase
    return e;
  endfunction

endpackage

// ----- rtl/csvs_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module csvs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/clock_sweep_victim_select.sv -----
// Top level of the clock-sweep victim selector: microcoded sequencer and datapath.
//
//   Channel  Ports                      Handshake
//   input    start, busy, in_item       taken at a rising edge with start high, busy low
//   result   out_valid, out_item        shown for one cycle, taken at the edge ending it
//
// After reset a clearing pass over every frame fills the frame and link memories;
// busy stays high for it. A read goes straight to the result step. Write-state and free
// first read the frame state and skip their write for an index out of range; free also
// skips a listed frame. Allocate pops the free list and sweeps the hand if it runs dry.
// The result appears the cycle after the final step, while the block is already idle;
// the receiver cannot stall, so a result never holds the input off.
module clock_sweep_victim_select
  import csvs_pkg::*;
#(
  parameter int NUM_FRAMES = NUM_FRAMES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int FW = $clog2(NUM_FRAMES);
  localparam int LW = FW + 1;
  localparam int CW = ((FW > 8) ? FW : 8) + 1;
  localparam logic [LW-1:0] LINK_END = LW'(NUM_FRAMES);
  localparam logic [LW-1:0] LAST_FRAME = LW'(NUM_FRAMES - 1);

  // Sequencer and datapath registers.
  logic [PC_W-1:0] pc_r, pc_nxt;
  logic [FW-1:0]   init_r, init_nxt;
  logic [LW-1:0]   head_r, head_nxt;
  logic [FW-1:0]   hand_r, hand_nxt;
  logic [31:0]     pass_r, pass_nxt;
  logic [31:0]     alloc_r, alloc_nxt;
  logic [LW-1:0]   tries_r, tries_nxt;
  logic [FW-1:0]   cur_r, cur_nxt;
  logic [FW-1:0]   victim_r, victim_nxt;
  logic            status_r, status_nxt;
  in_item_t        req_r, req_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  // Memory ports.
  logic            st_we, lk_we;
  logic [FW-1:0]   st_waddr, lk_waddr, rd_addr;
  frame_state_t    st_wdata, st_rd;
  logic [LW-1:0]   lk_wdata, lk_rd;

  ctl_word_t       cw;
  logic            cond_true;
  logic [CW-1:0]   idx_ext, vic_ext, hand_ext;
  logic            idx_ok;
  logic [FW-1:0]   idx_addr;
  logic [LW-1:0]   hand_inc;
  logic            rd_idle;

  csvs_ram #(.WIDTH($bits(frame_state_t)), .DEPTH(NUM_FRAMES)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rd)
  );

  csvs_ram #(.WIDTH(LW), .DEPTH(NUM_FRAMES)) u_link_ram (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (rd_addr),
    .rdata (lk_rd)
  );

  // Fetch the control word and derive common values.
  assign cw       = ucode_rom(pc_r);
  assign idx_ext  = CW'(req_r.frame_index);
  assign idx_ok   = idx_ext < CW'(NUM_FRAMES);
  assign idx_addr = idx_ext[FW-1:0];
  assign vic_ext  = CW'(victim_r);
  assign hand_ext = CW'(hand_r);
  assign hand_inc = {1'b0, hand_r} + LW'(1);
  assign rd_idle  = !st_rd.pinned && (st_rd.usage == 3'd0);

  // Branch condition.
  always_comb begin
    case (cw.cond)
      C_NEVER:     cond_true = 1'b0;
      C_ALWAYS:    cond_true = 1'b1;
      C_DISP:      cond_true = start;
      C_INIT_LAST: cond_true = ({1'b0, init_r} == LAST_FRAME);
      C_HEAD_END:  cond_true = (head_r == LINK_END);
      C_POP_HIT:   cond_true = rd_idle;
      C_SW_END:    cond_true = rd_idle || (st_rd.pinned && (tries_r == LW'(1)));
      C_IDX_BAD:   cond_true = !idx_ok;
      default:     cond_true = 1'b0;
    endcase
  end

  // Next step: jump on a true condition, else follow the fall-through field.
  always_comb begin
    if (cond_true) begin
      pc_nxt = (cw.cond == C_DISP) ? op_entry(in_item.op) : cw.tgt;
    end else begin
      case (cw.fnext)
        F_INC:   pc_nxt = pc_r + PC_W'(1);
        F_DEC:   pc_nxt = pc_r - PC_W'(1);
        F_STAY:  pc_nxt = pc_r;
        default: pc_nxt = P_IDLE;
      endcase
    end
  end

  // Datapath actions selected by the control word.
  always_comb begin
    init_nxt      = init_r;
    head_nxt      = head_r;
    hand_nxt      = hand_r;
    pass_nxt      = pass_r;
    alloc_nxt     = alloc_r;
    tries_nxt     = tries_r;
    cur_nxt       = cur_r;
    victim_nxt    = victim_r;
    status_nxt    = status_r;
    req_nxt       = req_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    st_we         = 1'b0;
    st_waddr      = cur_r;
    st_wdata      = st_rd;
    lk_we         = 1'b0;
    lk_waddr      = cur_r;
    lk_wdata      = LINK_END;
    rd_addr       = '0;
    case (cw.act)
      A_INIT: begin
        st_we    = 1'b1;
        st_waddr = init_r;
        st_wdata = '{in_list: 1'b1, pinned: 1'b0, usage: 3'd0};
        lk_we    = 1'b1;
        lk_waddr = init_r;
        lk_wdata = {1'b0, init_r} + LW'(1);
        init_nxt = init_r + FW'(1);
      end
      A_LATCH: begin
        if (start) begin
          req_nxt    = in_item;
          victim_nxt = '0;
          status_nxt = ST_OK;
        end
      end
      A_ALLOC: begin
        alloc_nxt = alloc_r + 32'd1;
      end
      A_RD_HEAD: begin
        rd_addr = head_r[FW-1:0];
        cur_nxt = head_r[FW-1:0];
      end
      A_POP: begin
        // Unlink the head entry; it leaves the list whether it is taken or dropped.
        head_nxt = lk_rd;
        lk_we    = 1'b1;
        lk_wdata = LINK_END;
        st_we    = 1'b1;
        st_wdata = '{in_list: 1'b0, pinned: st_rd.pinned, usage: st_rd.usage};
        if (rd_idle) begin
          victim_nxt = cur_r;
        end
      end
      A_SW_SETUP: begin
        tries_nxt = LINK_END;
      end
      A_RD_HAND: begin
        // Advance the hand before the frame is judged, counting a pass on wrap.
        rd_addr = hand_r;
        cur_nxt = hand_r;
        if (hand_inc == LINK_END) begin
          hand_nxt = '0;
          pass_nxt = pass_r + 32'd1;
        end else begin
          hand_nxt = hand_inc[FW-1:0];
        end
      end
      A_SW_EVAL: begin
        if (!st_rd.pinned) begin
          if (st_rd.usage != 3'd0) begin
            st_we     = 1'b1;
            st_wdata  = '{in_list: st_rd.in_list, pinned: 1'b0,
                          usage: st_rd.usage - 3'd1};
            tries_nxt = LINK_END;
          end else begin
            victim_nxt = cur_r;
          end
        end else begin
          tries_nxt = tries_r - LW'(1);
          if (tries_r == LW'(1)) begin
            victim_nxt = '0;
            status_nxt = ST_NO_FREE;
          end
        end
      end
      A_RD_IDX: begin
        rd_addr = idx_addr;
      end
      A_FREE_WR: begin
        // Push the frame unless it is already on the list.
        if (!st_rd.in_list) begin
          lk_we    = 1'b1;
          lk_waddr = idx_addr;
          lk_wdata = head_r;
          st_we    = 1'b1;
          st_waddr = idx_addr;
          st_wdata = '{in_list: 1'b1, pinned: st_rd.pinned, usage: st_rd.usage};
          head_nxt = {1'b0, idx_addr};
        end
      end
      A_STATE_WR: begin
        st_we    = 1'b1;
        st_waddr = idx_addr;
        st_wdata = '{in_list: st_rd.in_list, pinned: req_r.pinned,
                     usage: req_r.usage_val};
      end
      A_DONE: begin
        out_valid_nxt        = 1'b1;
        out_nxt.victim_index = vic_ext[7:0];
        out_nxt.status       = status_r;
        out_nxt.sweep_start  = hand_ext[7:0];
        out_nxt.passes_done  = pass_r;
        out_nxt.allocs_seen  = alloc_r;
        if (req_r.op == OP_READ) begin
          alloc_nxt = 32'd0;
        end
      end
      default: begin
      end
    endcase
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= P_INIT;
      init_r      <= '0;
      head_r      <= '0;
      hand_r      <= '0;
      pass_r      <= '0;
      alloc_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      init_r      <= init_nxt;
      head_r      <= head_nxt;
      hand_r      <= hand_nxt;
      pass_r      <= pass_nxt;
      alloc_r     <= alloc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    tries_r  <= tries_nxt;
    cur_r    <= cur_nxt;
    victim_r <= victim_nxt;
    status_r <= status_nxt;
    req_r    <= req_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (pc_r != P_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- rtl/csvs_checker.sv -----
// Port-level checker for the clock-sweep victim selector and its bind.
module csvs_checker
  import csvs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // An accepted item keeps the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // A result is shown only once the block has returned to idle.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // A result strobe lasts exactly one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // A failed allocation reports frame zero.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item.status == ST_NO_FREE)) |-> (out_item.victim_index == 8'd0))
    else $error("failed allocation reports a nonzero frame");

endmodule

bind clock_sweep_victim_select csvs_checker u_csvs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- tb/clock_sweep_victim_select_tb.sv -----
// Self-checking testbench for the clock-sweep victim selector, with its own frame pool model.
module clock_sweep_victim_select_tb;
  import csvs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAMES = NUM_FRAMES_DEF;
  localparam logic [8:0] LIST_END = 9'(FRAMES);
  localparam int MAX_GAP = 12;
  // Worst allocate: pop the whole list, then sweep every frame down from usage 7.
  localparam int WORST_ALLOC = 4 + 2 * FRAMES + 2 + 2 * (9 * FRAMES);
  localparam int ITEM_BUDGET = 1400;
  localparam int CYCLE_LIMIT = 4 * ITEM_BUDGET * (WORST_ALLOC + MAX_GAP) + 4 * FRAMES;
  localparam int TAIL_CYCLES = 16;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  // Model of the frame pool.
  logic [8:0]  next_free [FRAMES];
  bit          listed [FRAMES];
  logic [8:0]  free_top;
  logic [7:0]  hand_pos;
  logic [31:0] sweeps_done;
  logic [31:0] allocs_count;
  bit          pin_flag [FRAMES];
  logic [2:0]  usage_cnt [FRAMES];

  out_item_t pending_results[$];
  int error_count = 0;
  int sender_idle_pct = 0;
  int cycle_count = 0;

  clock_sweep_victim_select #(
    .NUM_FRAMES(FRAMES)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Put the pool model in its reset state.
  task automatic reset_pool();
    for (int i = 0; i < FRAMES; i++) begin
      next_free[i] = 9'(i + 1);
      listed[i]    = 1'b1;
      pin_flag[i]  = 1'b0;
      usage_cnt[i] = 3'd0;
    end
    free_top     = '0;
    hand_pos     = '0;
    sweeps_done  = '0;
    allocs_count = '0;
  endtask

  // Pop the free list, then sweep the hand; returns 0 when every frame is pinned.
  function automatic bit choose_victim(output logic [7:0] victim);
    int  f;
    int  tries;
    bit  found;
    bit  done;
    victim = '0;
    found  = 1'b0;
    done   = 1'b0;
    while (!done && free_top < LIST_END) begin
      f = int'(free_top);
      free_top = next_free[f];
      next_free[f] = LIST_END;
      listed[f] = 1'b0;
      if (!pin_flag[f] && usage_cnt[f] == 3'd0) begin
        victim = 8'(f);
        found  = 1'b1;
        done   = 1'b1;
      end
    end
    tries = FRAMES;
    while (!done) begin
      f = int'(hand_pos);
      if (f + 1 >= FRAMES) begin
        hand_pos = '0;
        sweeps_done++;
      end else begin
        hand_pos = 8'(f + 1);
      end
      if (!pin_flag[f]) begin
        if (usage_cnt[f] != 3'd0) begin
          usage_cnt[f]--;
          tries = FRAMES;
        end else begin
          victim = 8'(f);
          found  = 1'b1;
          done   = 1'b1;
        end
      end else begin
        tries--;
        if (tries == 0) done = 1'b1;
      end
    end
    return found;
  endfunction

  // Apply one request to the pool model and return the result it gives.
  function automatic out_item_t pool_step(in_item_t it);
    out_item_t   r;
    logic [7:0]  victim;
    logic [31:0] seen;
    int          idx;
    r = '0;
    r.status = ST_OK;
    idx = int'(it.frame_index);
    case (it.op)
      OP_ALLOC: begin
        allocs_count++;
        if (choose_victim(victim)) begin
          r.victim_index = victim;
        end else begin
          r.victim_index = '0;
          r.status = ST_NO_FREE;
        end
      end
      OP_FREE: begin
        if (idx < FRAMES && !listed[idx]) begin
          next_free[idx] = free_top;
          free_top = 9'(idx);
          listed[idx] = 1'b1;
        end
      end
      OP_WRITE: begin
        if (idx < FRAMES) begin
          pin_flag[idx]  = it.pinned;
          usage_cnt[idx] = it.usage_val;
        end
      end
      default: ;
    endcase
    seen = allocs_count;
    if (it.op == OP_READ) allocs_count = '0;
    r.sweep_start = hand_pos;
    r.passes_done = sweeps_done;
    r.allocs_seen = seen;
    return r;
  endfunction

  function automatic in_item_t pack_request(logic [1:0] op, logic [7:0] idx, logic pin,
                                            logic [2:0] usage);
    in_item_t it;
    it.op          = op;
    it.frame_index = idx;
    it.pinned      = pin;
    it.usage_val   = usage;
    return it;
  endfunction

  // Random request: mostly allocate, free and write, with hot and edge frames.
  function automatic in_item_t random_request();
    in_item_t it;
    int pick;
    int r;
    r = $urandom_range(99);
    if (r < 15)      it.frame_index = 8'($urandom_range(15));
    else if (r < 25) it.frame_index = ($urandom_range(1) != 0) ? 8'd255 : 8'd0;
    else             it.frame_index = 8'($urandom_range(255));
    it.pinned = ($urandom_range(99) < 25);
    r = $urandom_range(99);
    if (r < 45)      it.usage_val = 3'd0;
    else if (r < 85) it.usage_val = 3'($urandom_range(3, 1));
    else             it.usage_val = 3'($urandom_range(7, 4));
    pick = $urandom_range(99);
    if (pick < 35)      it.op = OP_ALLOC;
    else if (pick < 60) it.op = OP_FREE;
    else if (pick < 90) it.op = OP_WRITE;
    else                it.op = OP_READ;
    return it;
  endfunction

  task automatic report_failure(string msg);
    error_count++;
    $display("mismatch: %s", msg);
  endtask

  // Offer one item, wait for its acceptance, record its result, maybe idle afterwards.
  task automatic send_item(in_item_t it);
    int gap;
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(pool_step(it));
    if ($urandom_range(99) < sender_idle_pct) begin
      gap = $urandom_range(MAX_GAP, 1);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Reset values, list pops with discards, double free and read clearing.
  task automatic test_directed();
    send_item(pack_request(OP_READ, 8'd255, 1'b1, 3'd7));
    send_item(pack_request(OP_ALLOC, 8'd0, 1'b0, 3'd0));
    send_item(pack_request(OP_ALLOC, 8'd255, 1'b1, 3'd7));
    send_item(pack_request(OP_FREE, 8'd0, 1'b0, 3'd0));
    send_item(pack_request(OP_FREE, 8'd0, 1'b1, 3'd7));
    send_item(pack_request(OP_FREE, 8'd255, 1'b0, 3'd0));
    send_item(pack_request(OP_WRITE, 8'd0, 1'b0, 3'd7));
    send_item(pack_request(OP_WRITE, 8'd2, 1'b1, 3'd0));
    send_item(pack_request(OP_ALLOC, 8'd0, 1'b0, 3'd0));
    send_item(pack_request(OP_READ, 8'd0, 1'b0, 3'd0));
    send_item(pack_request(OP_READ, 8'd0, 1'b0, 3'd0));
    send_item(pack_request(OP_WRITE, 8'd255, 1'b1, 3'd7));
    send_item(pack_request(OP_WRITE, 8'd254, 1'b0, 3'd0));
    send_item(pack_request(OP_ALLOC, 8'd170, 1'b1, 3'd5));
    send_item(pack_request(OP_ALLOC, 8'd85, 1'b0, 3'd2));
    send_item(pack_request(OP_FREE, 8'd1, 1'b0, 3'd0));
    send_item(pack_request(OP_ALLOC, 8'd0, 1'b0, 3'd0));
    send_item(pack_request(OP_WRITE, 8'd0, 1'b0, 3'd0));
    send_item(pack_request(OP_READ, 8'd255, 1'b1, 3'd7));
  endtask

  // Every frame pinned: the allocate fails after a full pass, then recovers.
  task automatic test_all_pinned();
    for (int f = 0; f < FRAMES; f++)
      send_item(pack_request(OP_WRITE, 8'(f), 1'b1, 3'($urandom_range(7))));
    send_item(pack_request(OP_ALLOC, 8'd0, 1'b0, 3'd0));
    send_item(pack_request(OP_ALLOC, 8'd255, 1'b1, 3'd7));
    send_item(pack_request(OP_FREE, 8'd7, 1'b0, 3'd0));
    send_item(pack_request(OP_ALLOC, 8'd7, 1'b0, 3'd0));
    send_item(pack_request(OP_WRITE, 8'd9, 1'b0, 3'd2));
    send_item(pack_request(OP_ALLOC, 8'd0, 1'b0, 3'd0));
    send_item(pack_request(OP_READ, 8'd0, 1'b0, 3'd0));
    // Unpin part of the pool again so the random traffic starts from a usable state.
    for (int f = 0; f < 64; f++)
      send_item(pack_request(OP_WRITE, 8'(f), 1'b0, 3'($urandom_range(1))));
  endtask

  // The sender stops until every outstanding result has come back, then resumes.
  task automatic test_pause_for_results();
    for (int i = 0; i < 8; i++) send_item(random_request());
    hold_until_drained();
    for (int i = 0; i < 8; i++) send_item(random_request());
  endtask

  task automatic test_random_traffic(int count, int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) send_item(random_request());
  endtask

  // Compare each result with the oldest outstanding expectation.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf("result with nothing outstanding, victim %0d",
                                 out_item.victim_index));
      end else begin
        want = pending_results.pop_front();
        if (out_item.victim_index !== want.victim_index)
          report_failure($sformatf("victim_index got %0d want %0d",
                                   out_item.victim_index, want.victim_index));
        if (out_item.status !== want.status)
          report_failure($sformatf("status got %0d want %0d",
                                   out_item.status, want.status));
        if (out_item.sweep_start !== want.sweep_start)
          report_failure($sformatf("sweep_start got %0d want %0d",
                                   out_item.sweep_start, want.sweep_start));
        if (out_item.passes_done !== want.passes_done)
          report_failure($sformatf("passes_done got %0d want %0d",
                                   out_item.passes_done, want.passes_done));
        if (out_item.allocs_seen !== want.allocs_seen)
          report_failure($sformatf("allocs_seen got %0d want %0d",
                                   out_item.allocs_seen, want.allocs_seen));
      end
    end
  end

  // Watchdog against a hung block.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Test sequence.
  initial begin
    reset_pool();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 33;
    test_directed();
    test_all_pinned();
    test_pause_for_results();
    test_random_traffic(130, 33);
    test_random_traffic(130, 54);
    test_random_traffic(130, 0);
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", pending_results.size()));
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/csvs_pkg.sv
rtl/csvs_ram.sv
rtl/clock_sweep_victim_select.sv
rtl/csvs_checker.sv
tb/clock_sweep_victim_select_tb.sv
